// File: src/seg_isect_pkg.sv
// ---------------------------------------------------------------------------
// seg_isect_pkg
// Shared types and constants for the segment intersection pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package seg_isect_pkg;

  // Coordinate lanes of the interpolation path
  localparam int NUM_LANES = 2;
  localparam int LANE_X    = 0;
  localparam int LANE_Y    = 1;

  // Per-word status that travels beside the payload
  typedef struct packed {
    logic valid;
    logic hit;
    logic degen;
  } flags_t;

endpackage

`default_nettype wire

// File: src/seg_isect_cross.sv
// ---------------------------------------------------------------------------
// seg_isect_cross
// Front half: coordinate differences, cross products, sign test and the
// magnitudes that feed the interpolation (four register stages).
// ---------------------------------------------------------------------------
`default_nettype none

module seg_isect_cross
  import seg_isect_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  logic                                     in_valid,
  input  logic [8*COORD_WIDTH-1:0]                 in_data,
  output flags_t                                   flags_o,
  output logic [2*COORD_WIDTH+2:0]                 den_o,
  output logic [2*COORD_WIDTH+1:0]                 m1_o,
  output logic [NUM_LANES-1:0][COORD_WIDTH-1:0]    mag_o,
  output logic [NUM_LANES-1:0]                     neg_o,
  output logic [NUM_LANES-1:0][COORD_WIDTH-1:0]    base_o
);

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W + 2;  // product width
  localparam int CW = 2 * W + 3;  // cross product width

  // Field order in the input word
  localparam int A_SX = 0;
  localparam int A_SY = 1;
  localparam int A_EX = 2;
  localparam int A_EY = 3;
  localparam int B_SX = 4;
  localparam int B_SY = 5;
  localparam int B_EX = 6;
  localparam int B_EY = 7;

  logic signed [W:0] co [8];

  // Unpack and sign-extend the eight coordinates
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      co[k] = (W+1)'($signed(in_data[k*W +: W]));
    end
  end

  // Stage 1: differences
  logic              v1;
  logic signed [W:0] abx, aby, cdx1, cdy1;
  logic signed [W:0] e1x, e1y, e2x, e2y, f1x, f1y, f2x, f2y;
  logic [NUM_LANES-1:0][W-1:0] base1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx  <= co[A_EX] - co[A_SX];
      aby  <= co[A_EY] - co[A_SY];
      cdx1 <= co[B_EX] - co[B_SX];
      cdy1 <= co[B_EY] - co[B_SY];
      e1x  <= co[B_SX] - co[A_SX];
      e1y  <= co[B_SY] - co[A_SY];
      e2x  <= co[B_EX] - co[A_SX];
      e2y  <= co[B_EY] - co[A_SY];
      f1x  <= co[A_SX] - co[B_SX];
      f1y  <= co[A_SY] - co[B_SY];
      f2x  <= co[A_EX] - co[B_SX];
      f2y  <= co[A_EY] - co[B_SY];
      base1[LANE_X] <= in_data[B_SX*W +: W];
      base1[LANE_Y] <= in_data[B_SY*W +: W];
    end
  end

  // Stage 2: the eight products
  logic               v2;
  logic signed [PW-1:0] pc1a, pc1b, pc2a, pc2b, pd1a, pd1b, pd2a, pd2b;
  logic signed [W:0]  cdx2, cdy2;
  logic [NUM_LANES-1:0][W-1:0] base2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc1a  <= abx * e1y;
      pc1b  <= aby * e1x;
      pc2a  <= abx * e2y;
      pc2b  <= aby * e2x;
      pd1a  <= cdx1 * f1y;
      pd1b  <= cdy1 * f1x;
      pd2a  <= cdx1 * f2y;
      pd2b  <= cdy1 * f2x;
      cdx2  <= cdx1;
      cdy2  <= cdy1;
      base2 <= base1;
    end
  end

  // Stage 3: cross products
  logic                 v3;
  logic signed [CW-1:0] c1, c2, d1, d2;
  logic signed [W:0]    cdx3, cdy3;
  logic [NUM_LANES-1:0][W-1:0] base3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1    <= CW'(pc1a) - CW'(pc1b);
      c2    <= CW'(pc2a) - CW'(pc2b);
      d1    <= CW'(pd1a) - CW'(pd1b);
      d2    <= CW'(pd2a) - CW'(pd2b);
      cdx3  <= cdx2;
      cdy3  <= cdy2;
      base3 <= base2;
    end
  end

  // Stage 4: sign test, magnitudes and denominator
  logic                 c1_pos, c1_neg, c2_pos, c2_neg;
  logic                 d1_pos, d1_neg, d2_pos, d2_neg;
  logic                 hit4, degen4;
  logic signed [CW-1:0] c1_abs, c2_abs;
  logic signed [W:0]    dx_abs, dy_abs;

  always_comb begin
    c1_neg = c1[CW-1];
    c1_pos = !c1[CW-1] && (c1 != '0);
    c2_neg = c2[CW-1];
    c2_pos = !c2[CW-1] && (c2 != '0);
    d1_neg = d1[CW-1];
    d1_pos = !d1[CW-1] && (d1 != '0);
    d2_neg = d2[CW-1];
    d2_pos = !d2[CW-1] && (d2 != '0);
    // touching counts: only strictly equal signs reject
    hit4   = !((c1_pos && c2_pos) || (c1_neg && c2_neg)) &&
             !((d1_pos && d2_pos) || (d1_neg && d2_neg));
    degen4 = hit4 && (c1 == '0) && (c2 == '0);
    c1_abs = c1_neg ? -c1 : c1;
    c2_abs = c2_neg ? -c2 : c2;
    dx_abs = cdx3[W] ? -cdx3 : cdx3;
    dy_abs = cdy3[W] ? -cdy3 : cdy3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_o <= '0;
    end else if (en) begin
      flags_o.valid <= v3;
      flags_o.hit   <= hit4;
      flags_o.degen <= degen4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_o              <= c1_abs[PW-1:0];
      den_o             <= CW'(c1_abs[PW-1:0]) + CW'(c2_abs[PW-1:0]);
      mag_o[LANE_X]     <= dx_abs[W-1:0];
      mag_o[LANE_Y]     <= dy_abs[W-1:0];
      neg_o[LANE_X]     <= cdx3[W];
      neg_o[LANE_Y]     <= cdy3[W];
      base_o            <= base3;
    end
  end

endmodule

`default_nettype wire

// File: src/seg_isect_interp.sv
// ---------------------------------------------------------------------------
// seg_isect_interp
// Back half: split multiply of |c1| by each delta, a restoring divider with
// one quotient bit per stage, and the final offset from B start.
// ---------------------------------------------------------------------------
`default_nettype none

module seg_isect_interp
  import seg_isect_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     en,
  input  flags_t                                   flags_i,
  input  logic [2*COORD_WIDTH+2:0]                 den_i,
  input  logic [2*COORD_WIDTH+1:0]                 m1_i,
  input  logic [NUM_LANES-1:0][COORD_WIDTH-1:0]    mag_i,
  input  logic [NUM_LANES-1:0]                     neg_i,
  input  logic [NUM_LANES-1:0][COORD_WIDTH-1:0]    base_i,
  output flags_t                                   flags_o,
  output logic [NUM_LANES-1:0][COORD_WIDTH-1:0]    point_o
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = 2 * W + 3;  // denominator width
  localparam int HW = W + 1;      // half of |c1|
  localparam int PP = 2 * W + 1;  // partial product width
  localparam int NW = 3 * W + 2;  // numerator width

  // Stage 5: partial products of |c1| halves and |delta|
  flags_t                       flg5;
  logic [DW-1:0]                den5;
  logic [NUM_LANES-1:0][PP-1:0] pp_lo, pp_hi;
  logic [NUM_LANES-1:0][W-1:0]  base5;
  logic [NUM_LANES-1:0]         neg5;

  always_ff @(posedge clk) begin
    if (rst) begin
      flg5 <= '0;
    end else if (en) begin
      flg5 <= flags_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        pp_lo[l] <= PP'(m1_i[HW-1:0]) * PP'(mag_i[l]);
        pp_hi[l] <= PP'(m1_i[2*HW-1:HW]) * PP'(mag_i[l]);
      end
      den5  <= den_i;
      base5 <= base_i;
      neg5  <= neg_i;
    end
  end

  // Stage 6: numerator assembly
  flags_t                       flg6;
  logic [DW-1:0]                den6;
  logic [NUM_LANES-1:0][NW-1:0] num6;
  logic [NUM_LANES-1:0][W-1:0]  base6;
  logic [NUM_LANES-1:0]         neg6;

  always_ff @(posedge clk) begin
    if (rst) begin
      flg6 <= '0;
    end else if (en) begin
      flg6 <= flg5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        num6[l] <= (NW'(pp_hi[l]) << HW) + NW'(pp_lo[l]);
      end
      den6  <= den5;
      base6 <= base5;
      neg6  <= neg5;
    end
  end

  // Divider stages; the quotient never exceeds |delta|, so W bits suffice
  logic [NUM_LANES-1:0][NW-1:0] rem_d  [W-1];
  logic [DW-1:0]                den_d  [W-1];
  logic [NUM_LANES-1:0][W-1:0]  q_d    [W];
  flags_t                       flg_d  [W];
  logic [NUM_LANES-1:0][W-1:0]  base_d [W];
  logic [NUM_LANES-1:0]         neg_d  [W];

  for (genvar s = 0; s < W; s++) begin : g_div
    localparam int SH = W - 1 - s;

    logic [NUM_LANES-1:0][NW-1:0] rin;
    logic [NUM_LANES-1:0][W-1:0]  qin;
    logic [DW-1:0]                din;
    flags_t                       fin;
    logic [NUM_LANES-1:0][W-1:0]  bin;
    logic [NUM_LANES-1:0]         nin;
    logic [NW-1:0]                trial;
    logic [NUM_LANES-1:0][NW-1:0] rnext;
    logic [NUM_LANES-1:0]         ge;

    if (s == 0) begin : g_first
      assign rin = num6;
      assign qin = '0;
      assign din = den6;
      assign fin = flg6;
      assign bin = base6;
      assign nin = neg6;
    end else begin : g_rest
      assign rin = rem_d[s-1];
      assign qin = q_d[s-1];
      assign din = den_d[s-1];
      assign fin = flg_d[s-1];
      assign bin = base_d[s-1];
      assign nin = neg_d[s-1];
    end

    // Trial subtract of the shifted denominator
    assign trial = NW'(din) << SH;

    always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
        ge[l]    = (rin[l] >= trial);
        rnext[l] = ge[l] ? (rin[l] - trial) : rin[l];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        flg_d[s] <= '0;
      end else if (en) begin
        flg_d[s] <= fin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NUM_LANES; l++) begin
          q_d[s][l] <= {qin[l][W-2:0], ge[l]};
        end
        base_d[s] <= bin;
        neg_d[s]  <= nin;
      end
    end

    // The last stage needs no remainder or denominator
    if (s < W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_d[s] <= rnext;
          den_d[s] <= din;
        end
      end
    end
  end

  // Final stage: apply offset, zero on miss or collinear case
  logic pass_zero;
  assign pass_zero = !flg_d[W-1].hit || flg_d[W-1].degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      flags_o <= '0;
    end else if (en) begin
      flags_o <= flg_d[W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < NUM_LANES; l++) begin
        if (pass_zero) begin
          point_o[l] <= '0;
        end else if (neg_d[W-1][l]) begin
          point_o[l] <= base_d[W-1][l] - q_d[W-1][l];
        end else begin
          point_o[l] <= base_d[W-1][l] + q_d[W-1][l];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/seg_isect_skid.sv
// ---------------------------------------------------------------------------
// seg_isect_skid
// Output register with a one-word skid stage; frees the pipeline from the
// output handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module seg_isect_skid #(
  parameter int DATA_WIDTH = 34
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [DATA_WIDTH-1:0] in_data,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_data
);

  logic                  skid_v;
  logic [DATA_WIDTH-1:0] skid_data;
  logic                  take;

  // Pipeline moves only while the skid slot is free
  assign in_ready = !skid_v;
  assign take     = in_valid && !skid_v;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= skid_v || take;
      skid_v    <= 1'b0;
    end else if (take) begin
      skid_v <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_v ? skid_data : in_data;
    end else if (take) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: src/segment_intersection_point_top.sv
// ---------------------------------------------------------------------------
// segment_intersection_point_top
// Segment pair intersection test and crossing point, fully pipelined.
//
//   channel  | dir | payload
//   ---------+-----+-----------------------------------------------------
//   s_axis   | in  | tdata: a_start_x,a_start_y,a_end_x,a_end_y,
//            |     |        b_start_x,b_start_y,b_end_x,b_end_y
//   m_axis   | out | tdata: point_x,point_y  tuser: crossing,degenerate
//
// One word per cycle is accepted while s_axis_tready is high; the depth is set by
// the restoring divider that yields one quotient bit per stage.
// Synchronous reset clears all valid bits; payload registers are not reset.
// A stalled output word waits in the output register while one more word
// moves into the skid slot; s_axis_tready drops only while that slot is full.
// ---------------------------------------------------------------------------
`default_nettype none

module segment_intersection_point_top
  import seg_isect_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [8*COORD_WIDTH-1:0]               s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // point_x, point_y, zero fill
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
  // crossing, degenerate
  output logic [1:0]                             m_axis_tuser
);

  localparam int W      = COORD_WIDTH;
  localparam int OUT_W  = 2 * W + 2;
  localparam int OUT_TD = ((2 * W + 7) / 8) * 8;

  logic                            en;
  flags_t                          flg_c, flg_i;
  logic [2*W+2:0]                  den;
  logic [2*W+1:0]                  m1;
  logic [NUM_LANES-1:0][W-1:0]     mag, base, point;
  logic [NUM_LANES-1:0]            neg;
  logic [OUT_W-1:0]                res_word, out_word;

  assign s_axis_tready = en;

  // Cross products and sign test
  seg_isect_cross #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_cross (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_axis_tvalid),
    .in_data  (s_axis_tdata),
    .flags_o  (flg_c),
    .den_o    (den),
    .m1_o     (m1),
    .mag_o    (mag),
    .neg_o    (neg),
    .base_o   (base)
  );

  // Interpolation and division
  seg_isect_interp #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_interp (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .flags_i (flg_c),
    .den_i   (den),
    .m1_i    (m1),
    .mag_i   (mag),
    .neg_i   (neg),
    .base_i  (base),
    .flags_o (flg_i),
    .point_o (point)
  );

  // Result word: degenerate, crossing, point_y, point_x
  assign res_word = {flg_i.degen, flg_i.hit, point[LANE_Y], point[LANE_X]};

  seg_isect_skid #(
    .DATA_WIDTH(OUT_W)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (flg_i.valid),
    .in_data   (res_word),
    .in_ready  (en),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_word)
  );

  assign m_axis_tdata = OUT_TD'(out_word[2*W-1:0]);
  assign m_axis_tuser = out_word[OUT_W-1:2*W];

endmodule

`default_nettype wire

// File: src/seg_isect_checker.sv
// ---------------------------------------------------------------------------
// seg_isect_checker
// Port-level checks for the segment intersection block, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module seg_isect_checker #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tready,
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  input  logic [1:0]                         m_axis_tuser
);

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output word changed under stall");

  // Degenerate only on a crossing
  a_degen_cross: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tuser[1] || m_axis_tuser[0])
    else $error("degenerate without crossing");

  // No point reported on a miss or a collinear pair
  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (!m_axis_tuser[0] || m_axis_tuser[1]) |-> m_axis_tdata == '0)
    else $error("nonzero point without a proper crossing");

  // Input backpressure only while an output word is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // Reset leaves the output empty
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind segment_intersection_point_top seg_isect_checker #(
  .COORD_WIDTH(COORD_WIDTH)
) u_seg_isect_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: bench/segment_intersection_point_top_test.sv
// ---------------------------------------------------------------------------
// segment_intersection_point_top_test
// Streams segment pairs into the intersection pipeline and checks every
// result word against a typed-in answer or an in-bench fixed-point predictor.
// A short table of hand-picked pairs (extremes, touching ends, collinear and
// zero-length segments) runs first, then shaped random pairs with random gaps
// on both sides and one long output stall that backs up the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection_point_top_test;

  localparam int CW          = 16;
  localparam int OUT_W       = ((2*CW+7)/8)*8;
  localparam int LATENCY     = CW + 8;
  localparam int RANDOM_PAIRS = 1750;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 400;

  typedef logic signed [CW-1:0] coord_t;

  // One input word, fields in tdata order
  typedef struct packed {
    coord_t b_end_y;
    coord_t b_end_x;
    coord_t b_start_y;
    coord_t b_start_x;
    coord_t a_end_y;
    coord_t a_end_x;
    coord_t a_start_y;
    coord_t a_start_x;
  } seg_pair_t;

  typedef struct packed {
    logic   crossing;
    logic   degenerate;
    coord_t point_x;
    coord_t point_y;
  } isect_t;

  // Directed row: fixed flag selects the typed-in answer over the predictor
  typedef struct packed {
    logic      fixed;
    isect_t    answer;
    seg_pair_t pair;
  } pair_row_t;

  typedef enum int {
    SHAPE_WIDE,
    SHAPE_NEAR,
    SHAPE_CROSS,
    SHAPE_COLLINEAR,
    SHAPE_JOINED
  } shape_t;

  localparam coord_t C_MAX = 16'sh7fff;
  localparam coord_t C_MIN = 16'sh8000;
  localparam coord_t C_0   = 16'sd0;

  localparam int NUM_ROWS = 16;

  // Hand-picked pairs; fields listed b_end_y first down to a_start_x
  localparam pair_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // all zero: zero-length A, degenerate
    '{1'b1, '{1'b1, 1'b1, C_0, C_0}, '{C_0, C_0, C_0, C_0, C_0, C_0, C_0, C_0}},
    // all at max
    '{1'b1, '{1'b1, 1'b1, C_0, C_0},
      '{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX}},
    // all at min
    '{1'b1, '{1'b1, 1'b1, C_0, C_0},
      '{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN}},
    // plus sign crossing at the origin
    '{1'b1, '{1'b1, 1'b0, C_0, C_0},
      '{16'sd16, C_0, -16'sd16, C_0, C_0, 16'sd16, C_0, -16'sd16}},
    // parallel, offset: no crossing
    '{1'b1, '{1'b0, 1'b0, C_0, C_0},
      '{16'sd16, 16'sd16, 16'sd16, C_0, C_0, 16'sd16, C_0, C_0}},
    // B start touches A end
    '{1'b1, '{1'b1, 1'b0, 16'sd16, C_0},
      '{16'sd16, 16'sd16, C_0, 16'sd16, C_0, 16'sd16, C_0, C_0}},
    // collinear but disjoint
    '{1'b1, '{1'b1, 1'b1, C_0, C_0},
      '{C_0, 16'sd48, C_0, 16'sd32, C_0, 16'sd16, C_0, C_0}},
    // zero-length A lying on B
    '{1'b1, '{1'b1, 1'b1, C_0, C_0},
      '{16'sd16, 16'sd16, C_0, C_0, 16'sd8, 16'sd8, 16'sd8, 16'sd8}},
    // zero-length A off B
    '{1'b1, '{1'b0, 1'b0, C_0, C_0},
      '{16'sd16, 16'sd16, C_0, C_0, C_0, 16'sd8, C_0, 16'sd8}},
    // B end touches A interior
    '{1'b1, '{1'b1, 1'b0, 16'sd8, C_0},
      '{C_0, 16'sd8, 16'sd16, 16'sd8, C_0, 16'sd16, C_0, C_0}},
    // near miss past A end
    '{1'b1, '{1'b0, 1'b0, C_0, C_0},
      '{16'sd8, 16'sd17, -16'sd8, 16'sd17, C_0, 16'sd16, C_0, C_0}},
    // full-range diagonals
    '{1'b0, '{1'b0, 1'b0, C_0, C_0},
      '{C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN}},
    '{1'b0, '{1'b0, 1'b0, C_0, C_0},
      '{C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MAX}},
    '{1'b0, '{1'b0, 1'b0, C_0, C_0},
      '{C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN}},
    // uneven split, negative B deltas: quotient truncation
    '{1'b0, '{1'b0, 1'b0, C_0, C_0},
      '{-16'sd2, -16'sd7, 16'sd3, 16'sd10, 16'sd7, 16'sd1, -16'sd5, 16'sd1}},
    // A end lands inside B
    '{1'b0, '{1'b0, 1'b0, C_0, C_0},
      '{16'sd37, 16'sd29, -16'sd11, -16'sd3, 16'sd13, 16'sd13, -16'sd20, -16'sd41}}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [8*CW-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  isect_t pending_points [$];
  int     failures     = 0;
  int     words_in     = 0;
  int     words_out    = 0;
  int     hits_seen    = 0;
  int     degen_seen   = 0;

  always #4 clk = ~clk;

  segment_intersection_point_top #(
    .COORD_WIDTH(CW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic int sign_of(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint mag_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - uy * vx;
  endfunction

  // Offset along B by part/den of delta, truncated toward zero
  function automatic coord_t lerp_coord(longint base, longint delta,
                                        longint part, longint den);
    longint q;
    q = (part * mag_of(delta)) / den;
    return coord_t'((delta < 0) ? base - q : base + q);
  endfunction

  // Crossing test and crossing point for one segment pair
  function automatic isect_t predict_crossing(seg_pair_t p);
    longint asx, asy, aex, aey, bsx, bsy, bex, bey;
    longint abx, aby, cdx, cdy, c1, c2, d1, d2, part, den;
    isect_t r;
    asx = p.a_start_x; asy = p.a_start_y;
    aex = p.a_end_x;   aey = p.a_end_y;
    bsx = p.b_start_x; bsy = p.b_start_y;
    bex = p.b_end_x;   bey = p.b_end_y;
    abx = aex - asx;   aby = aey - asy;
    cdx = bex - bsx;   cdy = bey - bsy;
    c1 = cross2(abx, aby, bsx - asx, bsy - asy);
    c2 = cross2(abx, aby, bex - asx, bey - asy);
    d1 = cross2(cdx, cdy, asx - bsx, asy - bsy);
    d2 = cross2(cdx, cdy, aex - bsx, aey - bsy);
    r = '0;
    r.crossing = (sign_of(c1) * sign_of(c2) <= 0) && (sign_of(d1) * sign_of(d2) <= 0);
    if (r.crossing) begin
      part = mag_of(c1);
      den  = part + mag_of(c2);
      if (den == 0) begin
        r.degenerate = 1'b1;
      end else begin
        r.point_x = lerp_coord(bsx, cdx, part, den);
        r.point_y = lerp_coord(bsy, cdy, part, den);
      end
    end
    return r;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  // Random pair of a chosen shape; all coordinates stay in range
  function automatic seg_pair_t random_pair(shape_t shape);
    seg_pair_t p;
    int px, py, ux, uy, vx, vy, lim, ka, kb, kc, kd;
    p = '0;
    case (shape)
      SHAPE_WIDE: begin
        p = {$urandom, $urandom, $urandom, $urandom};
      end
      SHAPE_NEAR: begin
        p.a_start_x = coord_t'(rand_between(-8, 8));
        p.a_start_y = coord_t'(rand_between(-8, 8));
        p.a_end_x   = coord_t'(rand_between(-8, 8));
        p.a_end_y   = coord_t'(rand_between(-8, 8));
        p.b_start_x = coord_t'(rand_between(-8, 8));
        p.b_start_y = coord_t'(rand_between(-8, 8));
        p.b_end_x   = coord_t'(rand_between(-8, 8));
        p.b_end_y   = coord_t'(rand_between(-8, 8));
      end
      SHAPE_CROSS: begin
        // two segments through a shared center, with uneven arms
        lim = ($urandom_range(3, 0) == 0) ? 16000 : 400;
        px = rand_between(-16000, 16000);
        py = rand_between(-16000, 16000);
        ux = rand_between(-lim, lim);
        uy = rand_between(-lim, lim);
        vx = rand_between(-lim, lim);
        vy = rand_between(-lim, lim);
        p.a_start_x = coord_t'(px - ux);
        p.a_start_y = coord_t'(py - uy);
        p.a_end_x   = coord_t'(px + (ux >>> $urandom_range(2, 0)));
        p.a_end_y   = coord_t'(py + (uy >>> $urandom_range(2, 0)));
        p.b_start_x = coord_t'(px - (vx >>> $urandom_range(2, 0)));
        p.b_start_y = coord_t'(py - (vy >>> $urandom_range(2, 0)));
        p.b_end_x   = coord_t'(px + vx);
        p.b_end_y   = coord_t'(py + vy);
      end
      SHAPE_COLLINEAR: begin
        px = rand_between(-8000, 8000);
        py = rand_between(-8000, 8000);
        ux = rand_between(-64, 64);
        uy = rand_between(-64, 64);
        ka = rand_between(-100, 100);
        kb = rand_between(-100, 100);
        kc = rand_between(-100, 100);
        kd = rand_between(-100, 100);
        p.a_start_x = coord_t'(px + ka * ux);
        p.a_start_y = coord_t'(py + ka * uy);
        p.a_end_x   = coord_t'(px + kb * ux);
        p.a_end_y   = coord_t'(py + kb * uy);
        p.b_start_x = coord_t'(px + kc * ux);
        p.b_start_y = coord_t'(py + kc * uy);
        p.b_end_x   = coord_t'(px + kd * ux);
        p.b_end_y   = coord_t'(py + kd * uy);
      end
      default: begin
        // B hangs off one end of A
        p = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(1, 0) == 1) begin
          p.b_start_x = p.a_end_x;
          p.b_start_y = p.a_end_y;
        end else begin
          p.b_end_x = p.a_start_x;
          p.b_end_y = p.a_start_y;
        end
      end
    endcase
    return p;
  endfunction

  function automatic shape_t pick_shape();
    int roll;
    roll = int'($urandom_range(99, 0));
    if (roll < 30) return SHAPE_WIDE;
    if (roll < 60) return SHAPE_CROSS;
    if (roll < 75) return SHAPE_NEAR;
    if (roll < 85) return SHAPE_COLLINEAR;
    return SHAPE_JOINED;
  endfunction

  // Offer one word after a random gap; queue its answer when taken
  task automatic send_pair(input seg_pair_t p, input isect_t answer);
    int gap;
    gap = ((words_in / 100) % 4 == 1) ? 0 : int'($urandom_range(12, 0));
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do @(posedge clk); while (!s_axis_tready);
    pending_points = {pending_points, answer};
    words_in++;
    @(negedge clk);
  endtask

  // Output side: random stalls, one long hold, compare each word
  initial begin : result_sink
    int     gap;
    isect_t want;
    isect_t got;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (words_out == HOLD_AT) gap = HOLD_CYCLES;
      else if ((words_out / 150) % 4 == 2) gap = 0;
      else gap = int'($urandom_range(12, 0));
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got.crossing   = m_axis_tuser[0];
      got.degenerate = m_axis_tuser[1];
      got.point_x    = m_axis_tdata[CW-1:0];
      got.point_y    = m_axis_tdata[2*CW-1:CW];
      words_out++;
      hits_seen  += got.crossing;
      degen_seen += got.degenerate;
      if (pending_points.size() == 0) begin
        $error("unexpected result word: crossing %0b degenerate %0b point (%0d, %0d)",
               got.crossing, got.degenerate, got.point_x, got.point_y);
        failures++;
      end else begin
        want = pending_points.pop_front();
        if (got.crossing !== want.crossing) begin
          $error("crossing: expected %0b, got %0b", want.crossing, got.crossing);
          failures++;
        end
        if (got.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate, got.degenerate);
          failures++;
        end
        if (got.point_x !== want.point_x) begin
          $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
          failures++;
        end
        if (got.point_y !== want.point_y) begin
          $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
          failures++;
        end
      end
      @(negedge clk);
    end
  end

  // Stimulus and end of run
  initial begin : pair_source
    pair_row_t row;
    seg_pair_t p;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      send_pair(row.pair, row.fixed ? row.answer : predict_crossing(row.pair));
    end

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      p = random_pair(pick_shape());
      send_pair(p, predict_crossing(p));
    end
    s_axis_tvalid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    if (pending_points.size() != 0) begin
      $error("%0d expected words never arrived", pending_points.size());
      failures++;
    end
    $display("Checked %0d segment pairs in, %0d words out.", words_in, words_out);
    $display("Crossings: %0d, collinear or zero-length: %0d, mismatches: %0d.",
             hits_seen, degen_seen, failures);
    if (failures == 0) begin
      $display("segment_intersection_point_top test passed");
    end else begin
      $display("segment_intersection_point_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4_000_000;
    $display("segment_intersection_point_top test failed");
    $finish;
  end

endmodule

// File: segment_intersection_point_top.f
src/seg_isect_pkg.sv
src/seg_isect_cross.sv
src/seg_isect_interp.sv
src/seg_isect_skid.sv
src/segment_intersection_point_top.sv
src/seg_isect_checker.sv
bench/segment_intersection_point_top_test.sv
